// ===== hdl/cfe_pkg.sv =====
// package for the stuffed frame encoder: constants, command types, crc step
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cfe_pkg;

    localparam logic [7:0]  HEAD_BYTE  = 8'h01;
    localparam logic [7:0]  TAIL_BYTE  = 8'h03;
    localparam logic [7:0]  ESC_BYTE   = 8'h10;
    localparam logic [7:0]  ESC_OFFSET = 8'h80;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic {
        CMD_START,
        CMD_DATA
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  byte_a;
        logic [15:0] len;
        logic        close;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO,
        PH_TAIL
    } phase_t;

    function automatic logic [15:0] crc_add(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (x[15])
            begin
                x = {x[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                x = {x[14:0], 1'b0};
            end
        end
        return x;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cfe_in_if.sv =====
// input channel of the frame encoder: valid/ready plus request fields
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface cfe_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  frame_type;
    logic [15:0] payload_len;
    logic [7:0]  data_byte;

    modport source (output valid, output req_type, output frame_type,
                    output payload_len, output data_byte, input ready);
    modport sink   (input valid, input req_type, input frame_type,
                    input payload_len, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/cfe_out_if.sv =====
// output channel of the frame encoder: valid/ready plus wire byte fields
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface cfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;

    modport source (output valid, output out_byte, output run_last,
                    output frame_end, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input frame_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/cfe_front.sv =====
// front end: accepts requests, tracks the open frame, pushes commands
// depends on cfe_pkg and cfe_in_if
`timescale 1ns / 1ps
`default_nettype none

module cfe_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    cfe_in_if.sink                 req,
    input  wire cfe_pkg::fifo_stat_t stat,
    output cfe_pkg::cmd_t          cmd,
    output logic                   push
);
    import cfe_pkg::*;

    logic        open_reg, open_next;
    logic [15:0] left_reg, left_next;
    logic        accept;

    assign req.ready = !stat.full;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        open_next  = open_reg;
        left_next  = left_reg;
        push       = 1'b0;
        cmd.kind   = CMD_DATA;
        cmd.byte_a = req.data_byte;
        cmd.len    = req.payload_len;
        cmd.close  = 1'b0;
        if (req.req_type == REQ_START)
        begin
            cmd.kind   = CMD_START;
            cmd.byte_a = req.frame_type;
            cmd.close  = (req.payload_len == 16'd0);
            if (accept)
            begin
                push      = 1'b1;
                open_next = (req.payload_len != 16'd0);
                left_next = req.payload_len;
            end
        end
        else
        begin
            cmd.close = (left_reg == 16'd1);
            if (accept && open_reg)
            begin
                push      = 1'b1;
                left_next = left_reg - 16'd1;
                open_next = (left_reg != 16'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            left_reg <= 16'd0;
        end
        else
        begin
            open_reg <= open_next;
            left_reg <= left_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cfe_cmd_fifo.sv =====
// short command queue between front and back end
// depends on cfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module cfe_cmd_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire cfe_pkg::cmd_t       wr_cmd,
    input  wire logic                pop,
    output cfe_pkg::cmd_t            head,
    output cfe_pkg::fifo_stat_t      stat
);
    import cfe_pkg::*;

    cmd_t                mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]  count_reg;

    assign stat.full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + FIFO_CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - FIFO_CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cfe_back.sv =====
// back end: walks each command byte by byte, stuffs, runs the crc
// depends on cfe_pkg and cfe_out_if
`timescale 1ns / 1ps
`default_nettype none

module cfe_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfe_pkg::cmd_t       head,
    input  wire cfe_pkg::fifo_stat_t stat,
    output logic                     pop,
    cfe_out_if.source                frame
);
    import cfe_pkg::*;

    phase_t      phase_reg, phase_next, cur_phase;
    logic        busy_reg, busy_next;
    logic        esc_reg, esc_next;
    logic [15:0] crc_reg, crc_next;
    logic        ovalid_reg;
    logic [7:0]  obyte_reg, obyte_next;
    logic        olast_reg, olast_next;
    logic        oend_reg, oend_next;
    logic        go, stuffable, esc_first, final_step;
    logic [7:0]  raw;

    assign go        = (busy_reg || !stat.empty) && (!ovalid_reg || frame.ready);
    assign cur_phase = busy_reg ? phase_reg
                                : ((head.kind == CMD_START) ? PH_HEAD : PH_DATA);

    always_comb
    begin
        case (cur_phase)
            PH_HEAD:   raw = HEAD_BYTE;
            PH_TYPE:   raw = head.byte_a;
            PH_LEN_LO: raw = head.len[7:0];
            PH_LEN_HI: raw = head.len[15:8];
            PH_DATA:   raw = head.byte_a;
            PH_CRC_HI: raw = crc_reg[15:8];
            PH_CRC_LO: raw = crc_reg[7:0];
            PH_TAIL:   raw = TAIL_BYTE;
            default:   raw = TAIL_BYTE;
        endcase
        stuffable  = (cur_phase != PH_HEAD) && (cur_phase != PH_TAIL);
        esc_first  = stuffable && !esc_reg && (raw inside {HEAD_BYTE, TAIL_BYTE, ESC_BYTE});
        final_step = !esc_first
                     && (cur_phase == PH_TAIL
                         || ((cur_phase == PH_LEN_HI || cur_phase == PH_DATA)
                             && !head.close));
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        busy_next  = busy_reg;
        esc_next   = esc_reg;
        if (go)
        begin
            busy_next  = !final_step;
            esc_next   = esc_first;
            phase_next = cur_phase;
            if (!esc_first)
            begin
                case (cur_phase)
                    PH_HEAD:   phase_next = PH_TYPE;
                    PH_TYPE:   phase_next = PH_LEN_LO;
                    PH_LEN_LO: phase_next = PH_LEN_HI;
                    PH_LEN_HI: phase_next = PH_CRC_HI;
                    PH_DATA:   phase_next = PH_CRC_HI;
                    PH_CRC_HI: phase_next = PH_CRC_LO;
                    PH_CRC_LO: phase_next = PH_TAIL;
                    PH_TAIL:   phase_next = PH_HEAD;
                    default:   phase_next = PH_HEAD;
                endcase
            end
        end
    end

    // outputs
    always_comb
    begin
        pop        = go && final_step;
        crc_next   = crc_reg;
        olast_next = final_step;
        oend_next  = (cur_phase == PH_TAIL);
        if (esc_first)
        begin
            obyte_next = ESC_BYTE;
        end
        else if (esc_reg)
        begin
            obyte_next = raw + ESC_OFFSET;
        end
        else
        begin
            obyte_next = raw;
        end
        if (go && !esc_first)
        begin
            case (cur_phase)
                PH_HEAD:   crc_next = 16'd0;
                PH_TYPE,
                PH_LEN_LO,
                PH_LEN_HI,
                PH_DATA:   crc_next = crc_add(crc_reg, raw);
                default:   crc_next = crc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD;
            busy_reg   <= 1'b0;
            esc_reg    <= 1'b0;
            crc_reg    <= 16'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            esc_reg   <= esc_next;
            crc_reg   <= crc_next;
            if (go)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (frame.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            obyte_reg <= obyte_next;
            olast_reg <= olast_next;
            oend_reg  <= oend_next;
        end
    end

    assign frame.valid     = ovalid_reg;
    assign frame.out_byte  = obyte_reg;
    assign frame.run_last  = olast_reg;
    assign frame.frame_end = oend_reg;

endmodule

`default_nettype wire

// ===== hdl/crc_stuffed_frame_encoder_core.sv =====
// top level of the byte-stuffed frame encoder with crc-16/xmodem
// depends on cfe_pkg, cfe_in_if, cfe_out_if, cfe_front, cfe_cmd_fifo, cfe_back
`timescale 1ns / 1ps
`default_nettype none

// The encoder puts out one wire byte per clock while the output side is ready
// and a command is pending. A request transaction causes these wire bytes: a
// payload byte gives one, or two when stuffed, plus three to five more when it
// closes the frame; a start gives four to seven, and up to twelve for an empty
// payload. The byte sequencer in the back end and its single output register
// produce these bytes. Requests are taken every cycle while the four-entry
// command queue has room, so the front end runs ahead of the output by up to
// four transactions; stray payload bytes are dropped there.

module crc_stuffed_frame_encoder_core (
    input  wire logic clk,
    input  wire logic rst_n,
    cfe_in_if.sink    item,
    cfe_out_if.source frame
);
    import cfe_pkg::*;

    cmd_t       wr_cmd;
    cmd_t       head;
    fifo_stat_t stat;
    logic       push;
    logic       pop;

    cfe_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (item),
        .stat  (stat),
        .cmd   (wr_cmd),
        .push  (push)
    );

    cfe_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .head   (head),
        .stat   (stat)
    );

    cfe_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .stat  (stat),
        .pop   (pop),
        .frame (frame)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("command pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("command popped from empty queue");

    a_tail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.frame_end) |-> (frame.run_last && frame.out_byte == TAIL_BYTE))
        else $error("tail byte not marked last");

    a_pop_loads_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (frame.valid && frame.run_last))
        else $error("command retired without a last byte");

endmodule

`default_nettype wire
